### src/nps_pkg.sv
package nps_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam int TIME_W = 22;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrive;
		logic [15:0] burst;
		logic [7:0]  prio;
	} rec_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_TAIL,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              clr;
		logic              vld;
		logic              first;
		logic [TIME_W-1:0] now;
	} pick_ctl_t;

	typedef struct packed {
		logic             use_elig;
		rec_t             rec;
		logic [IDX_W-1:0] idx;
	} pick_res_t;

endpackage

### src/nps_pick.sv
module nps_pick (
	input  logic                clk,
	input  logic                arst_n,
	input  nps_pkg::pick_ctl_t  ctl,
	input  nps_pkg::rec_t       rec,
	input  logic [nps_pkg::IDX_W-1:0] idx,
	output nps_pkg::pick_res_t  res
);

	logic                      elig_found_q;
	nps_pkg::rec_t             elig_q;
	logic [nps_pkg::IDX_W-1:0] elig_idx_q;
	logic                      cand_found_q;
	nps_pkg::rec_t             cand_q;
	logic [nps_pkg::IDX_W-1:0] cand_idx_q;

	logic        is_elig;
	logic        elig_better;
	logic        cand_better;
	logic [39:0] rec_ckey;
	logic [39:0] cand_ckey;

	// The earliest-arrival key drops priority for the first slot of a schedule.
	assign rec_ckey  = {rec.arrive, (ctl.first ? 8'h00 : rec.prio), rec.burst};
	assign cand_ckey = {cand_q.arrive, (ctl.first ? 8'h00 : cand_q.prio), cand_q.burst};

	assign is_elig     = ({6'b0, rec.arrive} <= ctl.now);
	assign elig_better = !elig_found_q ||
		({rec.prio, rec.arrive, rec.burst} < {elig_q.prio, elig_q.arrive, elig_q.burst});
	assign cand_better = !cand_found_q || (rec_ckey < cand_ckey);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elig_found_q <= 1'b0;
			cand_found_q <= 1'b0;
		end else if (ctl.clr) begin
			elig_found_q <= 1'b0;
			cand_found_q <= 1'b0;
		end else if (ctl.vld) begin
			if (is_elig && elig_better) begin
				elig_found_q <= 1'b1;
			end
			if (cand_better) begin
				cand_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clr && ctl.vld) begin
			if (is_elig && elig_better) begin
				elig_q     <= rec;
				elig_idx_q <= idx;
			end
			if (cand_better) begin
				cand_q     <= rec;
				cand_idx_q <= idx;
			end
		end
	end

	always_comb begin
		res.use_elig = !ctl.first && elig_found_q;
		res.rec      = res.use_elig ? elig_q : cand_q;
		res.idx      = res.use_elig ? elig_idx_q : cand_idx_q;
	end

endmodule

### src/nonpreemptive_priority_scheduler.sv
// Channel  Valid       Ready       Payload
// item     item_valid  item_ready  proc_id, arrive_ms, burst_ms, prio, last_item
// result   res_valid   res_ready   out_id, finish_ms, turnaround_ms, waiting_ms, final_flag
//
// An accepted item loads a record if room is left; last_item set starts the schedule.
// Each result of a set of N records comes from a scan of the record memory
// through its single read port, a tail state for the last read, a calc state
// that picks and times the winner and an emit state that fills the output register.
// Reset clears the table count, the done marks and the clock; no items are
// taken during a schedule, and a stalled result holds the next one back.
module nonpreemptive_priority_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [15:0] proc_id,
	input  logic [15:0] arrive_ms,
	input  logic [15:0] burst_ms,
	input  logic [7:0]  prio,
	input  logic        last_item,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [15:0] out_id,
	output logic [21:0] finish_ms,
	output logic [21:0] turnaround_ms,
	output logic [21:0] waiting_ms,
	output logic        final_flag
);

	localparam int IDX_W = nps_pkg::IDX_W;
	localparam int CNT_W = nps_pkg::CNT_W;
	localparam int TIME_W = nps_pkg::TIME_W;

	nps_pkg::rec_t mem [nps_pkg::MAX_PROCS];
	nps_pkg::rec_t rd_data_s1;

	nps_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           k_q;
	logic [IDX_W-1:0]           rd_idx_q;
	logic                       vld_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic [nps_pkg::MAX_PROCS-1:0] done_q;
	logic [TIME_W-1:0]          clock_q;
	nps_pkg::rec_t              sel_q;
	logic                       res_valid_q;

	nps_pkg::pick_ctl_t ctl;
	nps_pkg::pick_res_t pres;

	logic              in_acc;
	logic              wr_en;
	logic              rd_en;
	logic              scan_end;
	logic              is_final;
	logic              emit_go;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] start;
	logic [TIME_W-1:0] fin;
	logic [TIME_W-1:0] arr_x;
	logic [TIME_W-1:0] bur_x;
	logic [TIME_W-1:0] tat;
	logic [TIME_W-1:0] wt;

	assign in_acc   = item_valid && item_ready;
	assign wr_en    = in_acc && (cnt_q < CNT_W'(nps_pkg::MAX_PROCS));
	assign rd_en    = (state_q == nps_pkg::ST_SCAN);
	assign scan_end = (CNT_W'(rd_idx_q) == (cnt_q - CNT_W'(1)));
	assign is_final = (k_q == (cnt_q - CNT_W'(1)));
	assign emit_go  = !res_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= '{id: proc_id, arrive: arrive_ms,
				burst: burst_ms, prio: prio};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	always_comb begin
		ctl.clr   = (in_acc && last_item) || (state_q == nps_pkg::ST_CALC);
		ctl.vld   = vld_s1 && !done_q[idx_s1];
		ctl.first = (k_q == '0);
		ctl.now   = clock_q;
	end

	nps_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rec    (rd_data_s1),
		.idx    (idx_s1),
		.res    (pres)
	);

	always_comb begin
		start = pres.use_elig ? clock_q : {6'b0, pres.rec.arrive};
		sum   = {1'b0, start} + {7'b0, pres.rec.burst};
		fin   = sum[TIME_W] ? nps_pkg::TIME_MAX : sum[TIME_W-1:0];
		arr_x = {6'b0, sel_q.arrive};
		bur_x = {6'b0, sel_q.burst};
		tat   = (clock_q >= arr_x) ? (clock_q - arr_x) : '0;
		wt    = (tat >= bur_x) ? (tat - bur_x) : '0;
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		case (state_q)
			nps_pkg::ST_LOAD: begin
				item_ready = 1'b1;
				if (in_acc && last_item) begin
					state_d = nps_pkg::ST_SCAN;
				end
			end
			nps_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = nps_pkg::ST_TAIL;
				end
			end
			nps_pkg::ST_TAIL: begin
				state_d = nps_pkg::ST_CALC;
			end
			nps_pkg::ST_CALC: begin
				state_d = nps_pkg::ST_EMIT;
			end
			nps_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = is_final ? nps_pkg::ST_LOAD : nps_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = nps_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nps_pkg::ST_LOAD;
			cnt_q       <= '0;
			k_q         <= '0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			done_q      <= '0;
			clock_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			idx_s1  <= rd_idx_q;
			if (state_q == nps_pkg::ST_EMIT && emit_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				nps_pkg::ST_LOAD: begin
					if (wr_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					rd_idx_q <= '0;
					k_q      <= '0;
				end
				nps_pkg::ST_SCAN: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				nps_pkg::ST_CALC: begin
					clock_q           <= fin;
					done_q[pres.idx]  <= 1'b1;
				end
				nps_pkg::ST_EMIT: begin
					if (emit_go) begin
						rd_idx_q    <= '0;
						if (is_final) begin
							cnt_q   <= '0;
							k_q     <= '0;
							done_q  <= '0;
							clock_q <= '0;
						end else begin
							k_q <= k_q + CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nps_pkg::ST_CALC) begin
			sel_q <= pres.rec;
		end
		if (state_q == nps_pkg::ST_EMIT && emit_go) begin
			out_id        <= sel_q.id;
			finish_ms     <= clock_q;
			turnaround_ms <= tat;
			waiting_ms    <= wt;
			final_flag    <= is_final;
		end
	end

	assign res_valid = res_valid_q;

	a_calc_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nps_pkg::ST_CALC |-> (cnt_q != '0) && (k_q < cnt_q))
		else $error("schedule step outside the loaded set");

	a_pick_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nps_pkg::ST_CALC |-> !done_q[pres.idx])
		else $error("finished process picked again");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_item |=> state_q == nps_pkg::ST_SCAN && cnt_q != '0)
		else $error("schedule did not start");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nps_pkg::ST_EMIT && emit_go && is_final |=>
		cnt_q == '0 && done_q == '0 && state_q == nps_pkg::ST_LOAD)
		else $error("set not cleared after the last result");

endmodule
